// File: src/sliding_window_average_macros.svh
// Assertion macros shared by the sliding window average RTL.
// Self-contained; included by the files that carry assertions.
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define SWA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swa assertion failed");
// next-cycle implication, disabled during reset
`define SWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swa assertion failed");
`else
`define SWA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SWA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/swa_pkg.sv
// Shared constants and types for the sliding window average block.
// No dependencies.
package swa_pkg;

   localparam int WINDOW_MAX_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // window length register
   localparam int              CFG_BITS         = 5;
   localparam logic [CFG_BITS-1:0] WINDOW_LEN_RESET = 5'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// File: src/sliding_window_average.sv
// Sliding window average top level: delay line RAM, accumulate sequencer, divider.
// Depends on swa_pkg, swa_ram, swa_div and sliding_window_average_macros.svh.
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_ready  req_sample, req_start_req
//   rsp_      out   rsp_valid/rsp_ready  rsp_average
//   csr_      in    csr_valid/csr_ready  csr_window_len
//
// A beat that leaves the window short of full keeps the sequencer idle.
// A beat that yields an average holds the block for L reads on the RAM read port,
// L being the effective window length, then for the divider at one quotient bit
// per cycle.
// Synchronous active-high reset clears fill count, write pointer and window length
// (back to 4); the delay line is not cleared. A waiting average does not block the
// next request beat; the sequencer holds before the output load.
`include "sliding_window_average_macros.svh"
module sliding_window_average #(
   parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_start_req,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   // window length register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swa_pkg::CFG_BITS-1:0]  csr_window_len
);

   localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
   localparam int PTR_BITS = $clog2(WINDOW_MAX);
   // wide enough for WINDOW_MAX samples plus sign headroom
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;

   swa_pkg::state_type state_ff, state_in;

   logic [swa_pkg::CFG_BITS-1:0] wlen_ff, wlen_in;
   logic [LEN_BITS-1:0]          fill_ff, fill_in;
   logic [PTR_BITS-1:0]          wp_ff, wp_in;
   logic [PTR_BITS-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [LEN_BITS-1:0]          len_ff, len_in;
   logic [LEN_BITS-1:0]          iss_ff, iss_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]       avg_ff, avg_in;

   logic [LEN_BITS-1:0]          eff_len;
   logic [LEN_BITS-1:0]          fill_base;
   logic                         req_beat;
   logic                         ram_rd_en;
   logic [SAMPLE_BITS-1:0]       ram_rd_data;
   logic                         div_start;
   logic                         div_done;
   logic signed [SUM_BITS-1:0]   div_quo;

   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // window length as used: zero means one, clamp at WINDOW_MAX
   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (32'(wlen_ff) > WINDOW_MAX) begin
         eff_len = LEN_BITS'(WINDOW_MAX);
      end else begin
         eff_len = LEN_BITS'(wlen_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      rd_ptr_in    = rd_ptr_ff;
      len_in       = len_ff;
      iss_in       = iss_ff;
      rd_vld_in    = 1'b0;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      ram_rd_en    = 1'b0;
      div_start    = 1'b0;
      req_ready    = 1'b0;
      fill_base    = req_start_req ? '0 : fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid && csr_ready) begin
         wlen_in = csr_window_len;
      end

      unique case (state_ff)
         swa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // fill count saturates; start flag restarts it at this beat
               fill_in   = (fill_base < LEN_BITS'(WINDOW_MAX)) ? fill_base + 1'b1
                                                               : fill_base;
               wp_in     = (wp_ff == PTR_BITS'(WINDOW_MAX - 1)) ? '0 : wp_ff + 1'b1;
               rd_ptr_in = wp_ff;
               len_in    = eff_len;
               iss_in    = '0;
               sum_in    = '0;
               if (fill_in >= eff_len) begin
                  state_in = swa_pkg::ST_READ;
               end
            end
         end
         swa_pkg::ST_READ: begin
            // walk back from the newest slot, one read per cycle
            if (iss_ff != len_ff) begin
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               iss_in    = iss_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == '0) ? PTR_BITS'(WINDOW_MAX - 1)
                                             : rd_ptr_ff - 1'b1;
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SUM_BITS'(signed'(ram_rd_data));
            end else if (iss_ff == len_ff) begin
               div_start = 1'b1;
               state_in  = swa_pkg::ST_DIV;
            end
         end
         swa_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = swa_pkg::ST_OUT;
            end
         end
         swa_pkg::ST_OUT: begin
            // load only once the previous average has left
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               avg_in       = div_quo[SAMPLE_BITS-1:0];
               state_in     = swa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swa_pkg::ST_IDLE;
         wlen_ff      <= swa_pkg::WINDOW_LEN_RESET;
         fill_ff      <= '0;
         wp_ff        <= '0;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      len_ff    <= len_in;
      sum_ff    <= sum_in;
      avg_ff    <= avg_in;
   end

   swa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_delay_line (
      .clock   (clock),
      .wr_en   (req_beat),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   swa_div #(
      .SUM_BITS (SUM_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;

   // a busy sequencer always has a full window behind it
   `SWA_ASSERT_IMPL(a_busy_full, clock, reset, state_ff != swa_pkg::ST_IDLE, fill_ff >= len_ff)
   // never more reads than the window length
   `SWA_ASSERT_IMPL(a_iss_bound, clock, reset, state_ff == swa_pkg::ST_READ, iss_ff <= len_ff)
   // divider finishes only while the sequencer waits on it
   `SWA_ASSERT_IMPL(a_div_owner, clock, reset, div_done, state_ff == swa_pkg::ST_DIV)
   // fill count saturates at the delay line depth
   `SWA_ASSERT_IMPL(a_fill_sat, clock, reset, 1'b1, fill_ff <= LEN_BITS'(WINDOW_MAX))

endmodule

// File: src/swa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/swa_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on sliding_window_average_macros.svh.
`include "sliding_window_average_macros.svh"
module swa_div #(
   parameter int SUM_BITS = 21,
   parameter int LEN_BITS = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_BITS-1:0] dividend,
   input  logic [LEN_BITS-1:0]        divisor,
   output logic                       done,
   output logic signed [SUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(SUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [LEN_BITS-1:0] dsr_ff, dsr_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;

   logic [LEN_BITS:0]   trial;
   logic [LEN_BITS:0]   diff;
   logic                qbit;
   logic [SUM_BITS-1:0] acc_step;

   always_comb begin
      trial    = {rem_ff, acc_ff[SUM_BITS-1]};
      diff     = trial - {1'b0, dsr_ff};
      qbit     = (trial >= {1'b0, dsr_ff});
      acc_step = {acc_ff[SUM_BITS-2:0], qbit};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[SUM_BITS-1];
         acc_in  = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         acc_in = acc_step;
         rem_in = qbit ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? (~acc_step + 1'b1) : acc_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // remainder always stays below the divisor
   `SWA_ASSERT_IMPL(a_rem_below_dsr, clock, reset, busy_ff, rem_ff < dsr_ff)
   // done is a single-cycle pulse
   `SWA_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   // a start always launches an iteration run
   `SWA_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff)

endmodule

// File: sim/swa_checker.sv
// Result checker for sliding_window_average: watches the request, response and window length
// channels, predicts each average and compares it with the response beats.
// Depends on swa_pkg.
`timescale 1ns / 100ps
module swa_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [swa_pkg::SAMPLE_BITS_DEF-1:0] req_sample,
   input  logic                                    req_start_req,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [swa_pkg::SAMPLE_BITS_DEF-1:0] rsp_average,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [swa_pkg::CFG_BITS-1:0]            csr_window_len,
   output int                                      avg_pending,
   output int                                      avg_failures
);

   localparam int TAP_COUNT = swa_pkg::WINDOW_MAX_DEF;
   localparam int SAMPLE_W  = swa_pkg::SAMPLE_BITS_DEF;
   localparam int CFG_W     = swa_pkg::CFG_BITS;
   localparam int PTR_W     = $clog2(TAP_COUNT);
   localparam int ACC_W     = SAMPLE_W + PTR_W + 1;

   logic signed [SAMPLE_W-1:0] taps [TAP_COUNT];
   logic [PTR_W-1:0]           wr_ptr;
   logic [PTR_W:0]             fill_cnt;
   logic [CFG_W-1:0]           win_len;
   logic signed [SAMPLE_W-1:0] avg_expected [$];
   logic signed [SAMPLE_W-1:0] want;
   int                         rsp_beats;

   initial begin
      avg_failures = 0;
      avg_pending  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] average check: %s", $realtime, msg);
      avg_failures = avg_failures + 1;
   endtask

   // one accepted sample: update the delay line and fill count, queue an average once full
   task automatic take_sample(input logic signed [SAMPLE_W-1:0] value, input logic first);
      logic [CFG_W-1:0]       eff;
      logic [PTR_W-1:0]       idx;
      logic signed [ACC_W-1:0] total;
      logic signed [ACC_W-1:0] quot;
      if (win_len == 0)
         eff = CFG_W'(1);
      else if (win_len > TAP_COUNT)
         eff = CFG_W'(TAP_COUNT);
      else
         eff = win_len;
      if (first)
         fill_cnt = '0;
      taps[wr_ptr] = value;
      wr_ptr = wr_ptr + 1'b1;
      if (fill_cnt < TAP_COUNT)
         fill_cnt = fill_cnt + 1'b1;
      if (fill_cnt >= eff) begin
         total = '0;
         idx   = wr_ptr;
         for (int k = 0; k < eff; k++) begin
            idx   = idx - 1'b1;
            total = total + ACC_W'(taps[idx]);
         end
         // signed divide truncates toward zero
         quot = total / $signed({{(ACC_W-CFG_W){1'b0}}, eff});
         avg_expected.push_back(quot[SAMPLE_W-1:0]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill_cnt  = '0;
         wr_ptr    = '0;
         win_len   = swa_pkg::WINDOW_LEN_RESET;
         rsp_beats = 0;
         avg_expected.delete();
      end else begin
         // response first: it always belongs to an earlier request beat
         if (rsp_valid && rsp_ready) begin
            if (avg_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected average %0d, nothing outstanding",
                                         rsp_average));
            end else begin
               want = avg_expected.pop_front();
               if (rsp_average !== want)
                  report_mismatch($sformatf("beat %0d: got %0d, expected %0d",
                                            rsp_beats, rsp_average, want));
            end
            rsp_beats++;
         end
         if (csr_valid && csr_ready)
            win_len = csr_window_len;
         if (req_valid && req_ready)
            take_sample(req_sample, req_start_req);
      end
      avg_pending = avg_expected.size();
   end

endmodule

// File: sim/testbench.sv
// Top level of the sliding_window_average regression: clock, reset, stimulus and verdict.
// Depends on swa_pkg, the sliding_window_average RTL and swa_checker.
`timescale 1ns / 100ps
module testbench;

   localparam int TAP_COUNT     = swa_pkg::WINDOW_MAX_DEF;
   localparam int SAMPLE_W      = swa_pkg::SAMPLE_BITS_DEF;
   localparam int CFG_W         = swa_pkg::CFG_BITS;
   localparam int RANDOM_ITEMS  = 1200;
   // room for the worst average, plus margin for the output register
   localparam int SETTLE_CYCLES = 64;
   localparam int RSP_HOLD_CYCLES = 600;
   // sized for the slowest run: near 1300 beats plus holds and pauses
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] MINUS_ONE  = 16'shFFFF;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_start_req = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CFG_W-1:0]           csr_window_len = '0;

   int avg_pending;
   int avg_failures;

   // no_gaps and the hold counts are shared between the sender and the receiver process
   bit no_gaps       = 1'b0;
   int hold_requests = 0;
   int holds_done    = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sliding_window_average i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_average    (rsp_average),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len)
   );

   swa_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_average    (rsp_average),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len),
      .avg_pending    (avg_pending),
      .avg_failures   (avg_failures)
   );

   // watchdog: a lost average or a stuck handshake ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sliding_window_average regression: fail");
         $finish;
      end
   end

   // response side: random back-pressure, plus one long hold-off on request.
   // During the hold-off the output register fills and the block stalls req_ready.
   initial begin
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         if (!no_gaps && $urandom_range(99) < 12)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= 1'b1;
      end
   end

   // one request beat; entered and left just after a falling edge.
   // valid stays high into the next beat unless a gap is drawn.
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic first);
      while (!no_gaps && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= value;
      req_start_req <= first;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // sender goes quiet until every queued average has been taken
   task automatic drain_averages();
      req_valid <= 1'b0;
      @(negedge clock);
      while (avg_pending != 0)
         @(negedge clock);
   endtask

   // drain, then let a no-result beat still in flight finish before touching the register
   task automatic settle_block();
      drain_averages();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_len(input logic [CFG_W-1:0] len);
      csr_valid      <= 1'b1;
      csr_window_len <= len;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mix of full-range values, both extremes and small values near zero
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned      roll;
      logic [SAMPLE_W-1:0] raw;
      roll = $urandom_range(99);
      if (roll < 8)
         return SAMPLE_MAX;
      if (roll < 16)
         return SAMPLE_MIN;
      if (roll < 30) begin
         raw = SAMPLE_W'($urandom_range(8));
         return raw - 16'd4;
      end
      raw = SAMPLE_W'($urandom);
      return raw;
   endfunction

   initial begin
      int phase;
      int phase_items;
      int n;
      int arr_len;
      int eff;
      bit cont;
      logic [CFG_W-1:0] len;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, window length still at its reset value of 4 ----
      // positive extreme, first average needs four written taps
      push_sample(SAMPLE_MAX, 1'b1);
      repeat (3) push_sample(SAMPLE_MAX, 1'b0);
      // negative extreme sliding in, four averages
      repeat (4) push_sample(SAMPLE_MIN, 1'b0);
      // new array: -1 -1 -1 2 sums to -1, truncates toward zero to 0
      push_sample(MINUS_ONE, 1'b1);
      push_sample(MINUS_ONE, 1'b0);
      push_sample(MINUS_ONE, 1'b0);
      push_sample(16'sd2, 1'b0);

      // zero length acts as one; array carries on across the change
      settle_block();
      write_window_len(5'd0);
      push_sample(-16'sd7, 1'b0);
      push_sample(16'sd7, 1'b0);

      // oversize length clamps to 16; fill goes 6 -> 16, average only on the last beat
      settle_block();
      write_window_len(5'd31);
      for (int k = 0; k < 10; k++)
         push_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX, 1'b0);

      // ---- random part: one window length per phase ----
      phase = 0;
      while (items_sent < RANDOM_ITEMS + 24) begin
         settle_block();
         case (phase)
            0: len = 5'd1;
            1: len = 5'd16;
            2: len = 5'd31;
            3: len = 5'd0;
            4: len = 5'd17;
            default: begin
               n = $urandom_range(99);
               if (n < 10)
                  len = 5'd0;
               else if (n < 20)
                  len = CFG_W'($urandom_range(31, 17));
               else
                  len = CFG_W'($urandom_range(16, 1));
            end
         endcase
         write_window_len(len);
         if (len == 0)
            eff = 1;
         else if (len > TAP_COUNT)
            eff = TAP_COUNT;
         else
            eff = int'(len);

         no_gaps = (phase == 3);
         if (phase == 2)
            hold_requests++;

         phase_items = $urandom_range(140, 60);
         n = 0;
         while (n < phase_items) begin
            // mostly arrays long enough to average; some cut short of a full window
            if (eff > 1 && $urandom_range(99) < 15)
               arr_len = $urandom_range(eff - 1, 1);
            else
               arr_len = eff + $urandom_range(3 * eff + 10, 0);
            cont = ($urandom_range(9) == 0);
            for (int k = 0; k < arr_len && n < phase_items; k++) begin
               push_sample(pick_sample(), (k == 0) && !cont);
               n++;
               if (phase == 5 && n == phase_items / 2)
                  drain_averages();
            end
         end
         phase++;
      end
      no_gaps = 1'b0;

      drain_averages();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (avg_failures == 0 && avg_pending == 0)
         $display("sliding_window_average regression: pass");
      else
         $display("sliding_window_average regression: fail");
      $finish;
   end

endmodule
